// ===== hdl/cbc_pkg.sv =====
// Shared codes and types for the cartridge bank controller.
package cbc_pkg;

	// Access codes on the opcode port
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAPPER_ON  = 2'd0;
	localparam logic [1:0] CFG_HAS_BATT   = 2'd1;
	localparam logic [1:0] CFG_BANK_COUNT = 2'd2;

	// Bus regions, address bits 15:13
	localparam logic [2:0] RGN_RAM_EN   = 3'b000;
	localparam logic [2:0] RGN_ROM_BANK = 3'b001;
	localparam logic [2:0] RGN_RAM_BANK = 3'b010;
	localparam logic [2:0] RGN_MODE     = 3'b011;
	localparam logic [2:0] RGN_EXT_RAM  = 3'b101;

	// Fixed bank geometry
	localparam int ROM_OFS_W = 14;
	localparam int RAM_OFS_W = 13;

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;

	// Where the read data of a beat comes from
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_ROM  = 2'd1;
	localparam logic [1:0] SRC_RAM  = 2'd2;
	localparam logic [1:0] SRC_FF   = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] src;
		logic       save;
	} cbc_ctl_t;

endpackage

// ===== hdl/cbc_ram.sv =====
// Generic single port RAM with registered read.
module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== hdl/cbc_bank_regs.sv =====
// Mapper registers, bus decode and store addressing for one access.
module cbc_bank_regs #(
	parameter int ROM_BANKS = 32,
	parameter int RAM_BANKS = 4,
	parameter int ROM_AW    = 19,
	parameter int RAM_AW    = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [2:0]          cfg_data,
	input  logic                accept,
	input  logic [1:0]          opcode,
	input  logic [15:0]         bus_address,
	input  logic [7:0]          write_data,
	input  logic [18:0]         image_address,
	output logic                rom_we,
	output logic [ROM_AW-1:0]   rom_addr,
	output logic                ram_we,
	output logic [RAM_AW-1:0]   ram_addr,
	output cbc_pkg::cbc_ctl_t   ctl
);
	import cbc_pkg::*;

	typedef logic [63:0][4:0] bank_wrap_t;

	// Every bank sum reduced by the ROM size
	function automatic bank_wrap_t bank_wrap_table();
		bank_wrap_t t;
		t = '0;
		for (int s = 0; s < 64; s++) begin
			t[s] = 5'(s % ROM_BANKS);
		end
		return t;
	endfunction

	localparam int         BANK_W    = ROM_AW - ROM_OFS_W;
	localparam logic [19:0] ROM_TOTAL = 20'(ROM_BANKS * (1 << ROM_OFS_W));
	localparam logic [2:0]  RAM_LIMIT = 3'(RAM_BANKS);
	localparam bank_wrap_t  BANK_WRAP = bank_wrap_table();

	logic       mapper_on_q;
	logic       has_battery_q;
	logic [2:0] banks_fitted_q;
	logic [4:0] rom_bank_q;
	logic [1:0] ram_bank_number_q;
	logic [1:0] ram_select_q;
	logic       banking_mode_q;
	logic       ram_enable_q;
	logic       save_pending_q;

	logic [2:0]  region;
	logic        ram_ready;
	logic        bus_wr;
	logic        ram_hit;
	logic [5:0]  bank_sum;
	logic [4:0]  bank_rem;
	logic [14:0] ram_index;

	assign region = bus_address[15:13];
	assign ram_ready = ram_enable_q
		&& ({1'b0, ram_select_q} < banks_fitted_q)
		&& ({1'b0, ram_select_q} < RAM_LIMIT);
	assign bus_wr  = accept && (opcode == OP_WRITE) && mapper_on_q;
	assign ram_hit = bus_wr && (region == RGN_EXT_RAM) && ram_ready;

	// Bank of the 16K window; the mapped window is offset by one bank
	always_comb begin
		if (mapper_on_q && (bus_address[15:14] != 2'b00)) begin
			bank_sum = {1'b0, rom_bank_q} + {4'b0, bus_address[15:14]} - 6'd1;
		end else begin
			bank_sum = {4'b0, bus_address[15:14]};
		end
	end

	// Wrap the bank number by the ROM size through a constant table
	assign bank_rem = BANK_WRAP[bank_sum];

	assign rom_we = accept && (opcode == OP_LOAD) && ({1'b0, image_address} < ROM_TOTAL);
	assign rom_addr = (opcode == OP_LOAD) ? image_address[ROM_AW-1:0]
		: {bank_rem[BANK_W-1:0], bus_address[ROM_OFS_W-1:0]};

	assign ram_index = {ram_select_q, bus_address[RAM_OFS_W-1:0]};
	assign ram_we    = ram_hit;
	assign ram_addr  = ram_index[RAM_AW-1:0];

	always_comb begin
		ctl.valid = accept;
		ctl.save  = save_pending_q | (ram_hit & has_battery_q);
		if (opcode != OP_READ) begin
			ctl.src = SRC_ZERO;
		end else if (!mapper_on_q || (region != RGN_EXT_RAM)) begin
			ctl.src = SRC_ROM;
		end else if (ram_ready) begin
			ctl.src = SRC_RAM;
		end else begin
			ctl.src = SRC_FF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_on_q    <= 1'b0;
			has_battery_q  <= 1'b0;
			banks_fitted_q <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAPPER_ON:  mapper_on_q    <= cfg_data[0];
				CFG_HAS_BATT:   has_battery_q  <= cfg_data[0];
				CFG_BANK_COUNT: banks_fitted_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q        <= 5'd1;
			ram_bank_number_q <= 2'd0;
			ram_select_q      <= 2'd0;
			banking_mode_q    <= 1'b0;
			ram_enable_q      <= 1'b0;
			save_pending_q    <= 1'b0;
		end else begin
			if (bus_wr) begin
				unique case (region)
					RGN_RAM_EN: begin
						ram_enable_q <= (write_data[3:0] == RAM_EN_KEY);
					end
					RGN_ROM_BANK: begin
						rom_bank_q <= (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
					end
					RGN_RAM_BANK: begin
						ram_bank_number_q <= write_data[1:0];
						if (banking_mode_q) begin
							ram_select_q <= write_data[1:0];
						end
					end
					RGN_MODE: begin
						banking_mode_q <= write_data[0];
						if (write_data[0]) begin
							ram_select_q <= ram_bank_number_q;
						end
					end
					default: ;
				endcase
			end
			save_pending_q <= ctl.save;
		end
	end
endmodule

// ===== hdl/cbc_result.sv =====
// Result stage: picks the read byte and drives the result strobe.
module cbc_result (
	input  logic              clk,
	input  logic              arst_n,
	input  cbc_pkg::cbc_ctl_t ctl,
	input  logic [7:0]        rom_rdata,
	input  logic [7:0]        ram_rdata,
	output logic              done,
	output logic [7:0]        read_data,
	output logic              save_needed
);
	import cbc_pkg::*;

	cbc_ctl_t   ctl_s1;
	logic [7:0] byte_sel;
	logic       done_s2;
	logic [7:0] read_data_s2;
	logic       save_s2;

	always_comb begin
		case (ctl_s1.src)
			SRC_ROM: byte_sel = rom_rdata;
			SRC_RAM: byte_sel = ram_rdata;
			SRC_FF:  byte_sel = OPEN_BUS;
			default: byte_sel = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			done_s2 <= 1'b0;
			save_s2 <= 1'b0;
		end else begin
			ctl_s1  <= ctl;
			done_s2 <= ctl_s1.valid;
			save_s2 <= ctl_s1.save;
		end
	end

	always_ff @(posedge clk) begin
		read_data_s2 <= byte_sel;
	end

	assign done        = done_s2;
	assign read_data   = read_data_s2;
	assign save_needed = save_s2;
endmodule

// ===== hdl/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: stores, clearing pass and stages.
//
// Usage: raise start with opcode, bus_address, write_data and image_address;
// the beat is taken at a clock edge where start is high and busy is low.
// A read returns the ROM or external RAM byte, a bus write updates the
// mapper registers or external RAM, and a load puts one byte of the ROM
// image into the ROM store. Every beat gives exactly one result.
// The result appears on read_data and save_needed with done high for one
// cycle, after the beat passes the ctl_s1 stage and the output registers;
// it cannot be held off.
// A new beat may be accepted on every cycle while busy is low, giving one
// access per clock; each store is a single port memory touched once per beat.
// Configuration (cfg_we, cfg_index, cfg_data) writes the mapper enable,
// battery flag and fitted RAM bank count; do this only while idle.
// Reset clears the mapper registers, but sets the ROM bank to 1; busy then
// stays high while every external RAM address is swept to zero.
// Configuration writes are taken during that sweep.
module cartridge_bank_controller #(
	parameter int ROM_BANKS = 32,
	parameter int RAM_BANKS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic [18:0] image_address,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        save_needed
);
	import cbc_pkg::*;

	localparam int ROM_DEPTH = ROM_BANKS * (1 << ROM_OFS_W);
	localparam int RAM_DEPTH = RAM_BANKS * (1 << RAM_OFS_W);
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_DEPTH - 1);

	logic              accept;
	logic              clearing_q;
	logic [RAM_AW-1:0] clr_addr_q;
	logic              rom_we;
	logic [ROM_AW-1:0] rom_addr;
	logic [7:0]        rom_rdata;
	logic              acc_ram_we;
	logic [RAM_AW-1:0] acc_ram_addr;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	cbc_ctl_t          ctl;

	assign busy   = clearing_q;
	assign accept = start && !clearing_q;

	// Sweep external RAM to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == RAM_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clearing_q | acc_ram_we;
	assign ram_addr  = clearing_q ? clr_addr_q : acc_ram_addr;
	assign ram_wdata = clearing_q ? 8'd0 : write_data;

	cbc_bank_regs #(
		.ROM_BANKS (ROM_BANKS),
		.RAM_BANKS (RAM_BANKS),
		.ROM_AW    (ROM_AW),
		.RAM_AW    (RAM_AW)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.opcode        (opcode),
		.bus_address   (bus_address),
		.write_data    (write_data),
		.image_address (image_address),
		.rom_we        (rom_we),
		.rom_addr      (rom_addr),
		.ram_we        (acc_ram_we),
		.ram_addr      (acc_ram_addr),
		.ctl           (ctl)
	);

	cbc_ram #(
		.WIDTH (8),
		.DEPTH (ROM_DEPTH)
	) u_rom (
		.clk   (clk),
		.we    (rom_we),
		.addr  (rom_addr),
		.wdata (write_data),
		.rdata (rom_rdata)
	);

	cbc_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cbc_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rom_rdata   (rom_rdata),
		.ram_rdata   (ram_rdata),
		.done        (done),
		.read_data   (read_data),
		.save_needed (save_needed)
	);
endmodule
